// ===== rtl/core/c2gs_pkg.sv =====
// Shared types, widths and the arctangent table for the galactic spherical converter.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package c2gs_pkg;

   // Field and datapath widths
   localparam int COORD_W = 32;            // Q16.16 coordinate
   localparam int OFS_W   = 33;            // exact offset from the observer
   localparam int DIST_W  = 33;            // unsigned Q17.16 distance
   localparam int ANGLE_W = 16;            // binary angle on the result
   localparam int ROOT_W  = 34;            // square root bits handled by the cells
   localparam int RAD_W   = 68;            // radicand and trial subtrahend
   localparam int XY_W    = 37;            // CORDIC x/y, covers the gain growth
   localparam int ZANG_W  = 34;            // CORDIC angle, 2^-32 turn units
   localparam int MAX_ITER = 32;           // table depth
   localparam int LAT_MAX = 16384;         // quarter turn

   // Register indexes on the configuration port
   localparam int CSR_IDX_W = 2;
   typedef enum logic [CSR_IDX_W-1:0] {
      REG_OBSERVER_X = 2'd0,
      REG_OBSERVER_Y = 2'd1,
      REG_OBSERVER_Z = 2'd2
   } reg_index_type;

   // Two square roots worked together, one digit per cell
   typedef struct packed {
      logic [RAD_W-1:0]  rem_3d;
      logic [ROOT_W-1:0] root_3d;
      logic [RAD_W-1:0]  rem_2d;
      logic [ROOT_W-1:0] root_2d;
   } sqrt_pair_type;

   // Vector and accumulated angle of one CORDIC
   typedef struct packed {
      logic signed [XY_W-1:0]   x;
      logic signed [XY_W-1:0]   y;
      logic signed [ZANG_W-1:0] z;
   } cordic_vec_type;

   // atan(2^-i) in 2^-32 turn units, truncated
   function automatic logic [31:0] atan_entry(input int i);
      logic [31:0] v;
      case (i)
         0: v = 32'h20000000;  1: v = 32'h12E4051D;  2: v = 32'h09FB385B;
         3: v = 32'h051111D4;  4: v = 32'h028B0D43;  5: v = 32'h0145D7E1;
         6: v = 32'h00A2F61E;  7: v = 32'h00517C55;  8: v = 32'h0028BE53;
         9: v = 32'h00145F2E; 10: v = 32'h000A2F98; 11: v = 32'h000517CC;
         12: v = 32'h00028BE6; 13: v = 32'h000145F3; 14: v = 32'h0000A2F9;
         15: v = 32'h0000517C; 16: v = 32'h000028BE; 17: v = 32'h0000145F;
         18: v = 32'h00000A2F; 19: v = 32'h00000517; 20: v = 32'h0000028B;
         21: v = 32'h00000145; 22: v = 32'h000000A2; 23: v = 32'h00000051;
         24: v = 32'h00000028; 25: v = 32'h00000014; 26: v = 32'h0000000A;
         27: v = 32'h00000005; 28: v = 32'h00000002; 29: v = 32'h00000001;
         default: v = 32'h00000000;
      endcase
      return v;
   endfunction

   // Magnitude of an offset, always below 2^32
   function automatic logic [COORD_W-1:0] offset_mag(input logic signed [OFS_W-1:0] v);
      logic signed [OFS_W-1:0] a;
      a = v[OFS_W-1] ? -v : v;
      return a[COORD_W-1:0];
   endfunction

   // Fold the left half plane onto the right one; half turn start angle
   function automatic cordic_vec_type cordic_init(input logic signed [XY_W-1:0] x,
                                                  input logic signed [XY_W-1:0] y);
      cordic_vec_type v;
      if (x[XY_W-1]) begin
         v.x = -x;
         v.y = -y;
         v.z = ZANG_W'(34'sh0_8000_0000);
      end else begin
         v.x = x;
         v.y = y;
         v.z = '0;
      end
      return v;
   endfunction

endpackage
`default_nettype wire

// ===== rtl/core/c2gs_sqrt_cell.sv =====
// One digit of two restoring square roots, with a delay slot for side data.
// Depends on c2gs_pkg.
`timescale 1ns / 1ps
`default_nettype none
module c2gs_sqrt_cell #(
   parameter int BIT     = 0,
   parameter int PASS_W  = 1
) (
   input  wire                           clock,
   input  wire                           reset,
   input  wire                           advance,
   input  wire c2gs_pkg::sqrt_pair_type  pair_in,
   input  wire [PASS_W-1:0]              pass_in,
   output c2gs_pkg::sqrt_pair_type       pair_out,
   output logic [PASS_W-1:0]             pass_out
);
   localparam int RW = c2gs_pkg::RAD_W;

   c2gs_pkg::sqrt_pair_type pair_in_w;
   c2gs_pkg::sqrt_pair_type pair_ff;
   logic [PASS_W-1:0]       pass_ff;
   logic [RW-1:0]           trial_3d;
   logic [RW-1:0]           trial_2d;
   logic [RW-1:0]           digit_sq;

   // Trial subtrahend: (2r + 2^b) * 2^b
   always_comb begin
      digit_sq  = RW'(1) << (2 * BIT);
      trial_3d  = (RW'(pair_in.root_3d) << (BIT + 1)) | digit_sq;
      trial_2d  = (RW'(pair_in.root_2d) << (BIT + 1)) | digit_sq;
      pair_in_w = pair_in;
      if (pair_in.rem_3d >= trial_3d) begin
         pair_in_w.rem_3d       = pair_in.rem_3d - trial_3d;
         pair_in_w.root_3d[BIT] = 1'b1;
      end
      if (pair_in.rem_2d >= trial_2d) begin
         pair_in_w.rem_2d       = pair_in.rem_2d - trial_2d;
         pair_in_w.root_2d[BIT] = 1'b1;
      end
   end

   // Hand on to the next cell
   always_ff @(posedge clock) begin
      if (advance) begin
         pair_ff <= pair_in_w;
      end
   end

   // Side data carries the valid mark; clear it on reset
   always_ff @(posedge clock) begin
      if (reset) begin
         pass_ff <= '0;
      end else if (advance) begin
         pass_ff <= pass_in;
      end
   end

   assign pair_out = pair_ff;
   assign pass_out = pass_ff;
endmodule
`default_nettype wire

// ===== rtl/core/c2gs_cordic_cell.sv =====
// One vectoring CORDIC iteration with a fixed shift, plus a delay slot for side data.
// Depends on c2gs_pkg.
`timescale 1ns / 1ps
`default_nettype none
module c2gs_cordic_cell #(
   parameter int STAGE  = 0,
   parameter int PASS_W = 1
) (
   input  wire                            clock,
   input  wire                            reset,
   input  wire                            advance,
   input  wire c2gs_pkg::cordic_vec_type  vec_in,
   input  wire [PASS_W-1:0]               pass_in,
   output c2gs_pkg::cordic_vec_type       vec_out,
   output logic [PASS_W-1:0]              pass_out
);
   c2gs_pkg::cordic_vec_type    vec_in_w;
   c2gs_pkg::cordic_vec_type    vec_ff;
   logic [PASS_W-1:0]           pass_ff;
   logic signed [c2gs_pkg::XY_W-1:0]   xs;
   logic signed [c2gs_pkg::XY_W-1:0]   ys;
   logic signed [c2gs_pkg::ZANG_W-1:0] step;

   // Rotate towards the x axis; both updates use the old values
   always_comb begin
      xs   = vec_in.x >>> STAGE;
      ys   = vec_in.y >>> STAGE;
      step = c2gs_pkg::ZANG_W'(c2gs_pkg::atan_entry(STAGE));
      if (!vec_in.y[c2gs_pkg::XY_W-1] && (vec_in.y != '0)) begin
         vec_in_w.x = vec_in.x + ys;
         vec_in_w.y = vec_in.y - xs;
         vec_in_w.z = vec_in.z + step;
      end else begin
         vec_in_w.x = vec_in.x - ys;
         vec_in_w.y = vec_in.y + xs;
         vec_in_w.z = vec_in.z - step;
      end
   end

   // Hand on to the next cell
   always_ff @(posedge clock) begin
      if (advance) begin
         vec_ff <= vec_in_w;
      end
   end

   // Side data carries the valid mark; clear it on reset
   always_ff @(posedge clock) begin
      if (reset) begin
         pass_ff <= '0;
      end else if (advance) begin
         pass_ff <= pass_in;
      end
   end

   assign vec_out  = vec_ff;
   assign pass_out = pass_ff;
endmodule
`default_nettype wire

// ===== rtl/core/cartesian_to_galactic_spherical.sv =====
// Cartesian to galactic spherical converter: offset, squares, square root cells, CORDIC cells.
// Depends on c2gs_pkg, c2gs_sqrt_cell and c2gs_cordic_cell.
// Throughput: one request per cycle; the whole chain advances together and
// holds only while a result sits in the output register untaken.
// Reset clears the valid marks and the observer position to zero.
`timescale 1ns / 1ps
`default_nettype none
module cartesian_to_galactic_spherical #(
   parameter int CORDIC_STAGES = 16
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [95:0] req_tdata,    // pos_x [31:0], pos_y [63:32], pos_z [95:64]
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [71:0] rsp_tdata,    // distance [32:0], latitude [48:33], longitude [64:49], zero
   input  wire         csr_valid,
   output logic        csr_ready,
   input  wire  [1:0]  csr_index,
   input  wire  [31:0] csr_data
);
   localparam int NITER  = (CORDIC_STAGES > 32) ? 32 : CORDIC_STAGES;
   localparam int OW     = c2gs_pkg::OFS_W;
   localparam int CW     = c2gs_pkg::COORD_W;
   localparam int NROOT  = c2gs_pkg::ROOT_W;
   localparam int XW     = c2gs_pkg::XY_W;
   localparam int ZW     = c2gs_pkg::ZANG_W;
   localparam int DW     = c2gs_pkg::DIST_W;
   localparam int AW     = c2gs_pkg::ANGLE_W;
   localparam int SQ_PW  = 1 + 3 * OW;
   localparam int LAT_PW = DW + 1;
   localparam int LON_PW = 2;

   logic advance;

   // Observer position
   logic [CW-1:0] obs_x_ff, obs_y_ff, obs_z_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         obs_x_ff <= '0;
         obs_y_ff <= '0;
         obs_z_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (c2gs_pkg::reg_index_type'(csr_index))
            c2gs_pkg::REG_OBSERVER_X: obs_x_ff <= csr_data;
            c2gs_pkg::REG_OBSERVER_Y: obs_y_ff <= csr_data;
            c2gs_pkg::REG_OBSERVER_Z: obs_z_ff <= csr_data;
            default: ;
         endcase
      end
   end
   assign csr_ready = 1'b1;

   // Stage 0: offsets, quarter turn, magnitudes
   logic signed [OW-1:0] dx_in, dy_in, dz_in;
   logic signed [OW-1:0] lx_in, ly_in, lz_in;
   always_comb begin
      dx_in = $signed({req_tdata[31], req_tdata[31:0]}) - $signed({obs_x_ff[31], obs_x_ff});
      dy_in = $signed({req_tdata[63], req_tdata[63:32]}) - $signed({obs_y_ff[31], obs_y_ff});
      dz_in = $signed({req_tdata[95], req_tdata[95:64]}) - $signed({obs_z_ff[31], obs_z_ff});
      lx_in = -dy_in;
      ly_in = dx_in;
      lz_in = dz_in;
   end

   logic                 s0_valid_ff, s1_valid_ff, s2_valid_ff;
   logic signed [OW-1:0] s0_lx_ff, s0_ly_ff, s0_lz_ff;
   logic [CW-1:0]        s0_mx_ff, s0_my_ff, s0_mz_ff;
   logic signed [OW-1:0] s1_lx_ff, s1_ly_ff, s1_lz_ff;
   logic [2*CW-1:0]      s1_sx_ff, s1_sy_ff, s1_sz_ff;
   logic signed [OW-1:0] s2_lx_ff, s2_ly_ff, s2_lz_ff;
   c2gs_pkg::sqrt_pair_type s2_pair_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else if (advance) begin
         s0_valid_ff <= req_tvalid;
         s1_valid_ff <= s0_valid_ff;
         s2_valid_ff <= s1_valid_ff;
      end
   end

   // Offsets, squares and sums of squares
   always_ff @(posedge clock) begin
      if (advance) begin
         s0_lx_ff <= lx_in;
         s0_ly_ff <= ly_in;
         s0_lz_ff <= lz_in;
         s0_mx_ff <= c2gs_pkg::offset_mag(lx_in);
         s0_my_ff <= c2gs_pkg::offset_mag(ly_in);
         s0_mz_ff <= c2gs_pkg::offset_mag(lz_in);
         s1_lx_ff <= s0_lx_ff;
         s1_ly_ff <= s0_ly_ff;
         s1_lz_ff <= s0_lz_ff;
         s1_sx_ff <= s0_mx_ff * s0_mx_ff;
         s1_sy_ff <= s0_my_ff * s0_my_ff;
         s1_sz_ff <= s0_mz_ff * s0_mz_ff;
         s2_lx_ff <= s1_lx_ff;
         s2_ly_ff <= s1_ly_ff;
         s2_lz_ff <= s1_lz_ff;
         s2_pair_ff.rem_3d  <= c2gs_pkg::RAD_W'(s1_sx_ff) + c2gs_pkg::RAD_W'(s1_sy_ff)
                               + c2gs_pkg::RAD_W'(s1_sz_ff);
         s2_pair_ff.rem_2d  <= c2gs_pkg::RAD_W'(s1_sx_ff) + c2gs_pkg::RAD_W'(s1_sy_ff);
         s2_pair_ff.root_3d <= '0;
         s2_pair_ff.root_2d <= '0;
      end
   end

   // Square root cells, most significant digit first
   c2gs_pkg::sqrt_pair_type sq_pair [0:NROOT];
   logic [SQ_PW-1:0]        sq_pass [0:NROOT];
   assign sq_pair[0] = s2_pair_ff;
   assign sq_pass[0] = {s2_valid_ff, s2_lx_ff, s2_ly_ff, s2_lz_ff};

   for (genvar k = 0; k < NROOT; k++) begin : g_sqrt
      c2gs_sqrt_cell #(
         .BIT    (NROOT - 1 - k),
         .PASS_W (SQ_PW)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .advance  (advance),
         .pair_in  (sq_pair[k]),
         .pass_in  (sq_pass[k]),
         .pair_out (sq_pair[k+1]),
         .pass_out (sq_pass[k+1])
      );
   end

   // CORDIC set-up: fold, zero vector marks
   logic signed [OW-1:0] r_lx, r_ly, r_lz;
   logic                 r_valid;
   logic signed [XW-1:0] lat_x_in, lat_y_in, lon_x_in, lon_y_in;
   assign {r_valid, r_lx, r_ly, r_lz} = sq_pass[NROOT];
   assign lat_x_in = XW'($signed({1'b0, sq_pair[NROOT].root_2d}));
   assign lat_y_in = XW'(r_lz);
   assign lon_x_in = XW'(r_lx);
   assign lon_y_in = XW'(r_ly);

   c2gs_pkg::cordic_vec_type lat_vec [0:NITER];
   c2gs_pkg::cordic_vec_type lon_vec [0:NITER];
   logic [LAT_PW-1:0]        lat_pass [0:NITER];
   logic [LON_PW-1:0]        lon_pass [0:NITER];
   c2gs_pkg::cordic_vec_type lat_init_ff, lon_init_ff;
   logic [DW-1:0]            init_dist_ff;
   logic                     init_lat_zero_ff, init_lon_zero_ff, init_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         init_valid_ff <= 1'b0;
      end else if (advance) begin
         init_valid_ff <= r_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         lat_init_ff      <= c2gs_pkg::cordic_init(lat_x_in, lat_y_in);
         lon_init_ff      <= c2gs_pkg::cordic_init(lon_x_in, lon_y_in);
         init_dist_ff     <= sq_pair[NROOT].root_3d[DW-1:0];
         init_lat_zero_ff <= (lat_x_in == '0) && (lat_y_in == '0);
         init_lon_zero_ff <= (lon_x_in == '0) && (lon_y_in == '0);
      end
   end

   assign lat_vec[0]  = lat_init_ff;
   assign lon_vec[0]  = lon_init_ff;
   assign lat_pass[0] = {init_dist_ff, init_lat_zero_ff};
   assign lon_pass[0] = {init_valid_ff, init_lon_zero_ff};

   // CORDIC cells for latitude and longitude, side by side
   for (genvar i = 0; i < NITER; i++) begin : g_cordic
      c2gs_cordic_cell #(
         .STAGE  (i),
         .PASS_W (LAT_PW)
      ) u_lat (
         .clock    (clock),
         .reset    (reset),
         .advance  (advance),
         .vec_in   (lat_vec[i]),
         .pass_in  (lat_pass[i]),
         .vec_out  (lat_vec[i+1]),
         .pass_out (lat_pass[i+1])
      );
      c2gs_cordic_cell #(
         .STAGE  (i),
         .PASS_W (LON_PW)
      ) u_lon (
         .clock    (clock),
         .reset    (reset),
         .advance  (advance),
         .vec_in   (lon_vec[i]),
         .pass_in  (lon_pass[i]),
         .vec_out  (lon_vec[i+1]),
         .pass_out (lon_pass[i+1])
      );
   end

   // Round the angles to 16 bits, clamp latitude, wrap longitude
   logic [DW-1:0]        f_dist;
   logic                 f_lat_zero, f_lon_zero, f_valid;
   logic signed [ZW-1:0] lat_round;
   logic signed [ZW-17:0] lat_coarse;
   logic [AW-1:0]        lat_in, lon_in;
   logic [32:0]          lon_round;
   assign {f_dist, f_lat_zero} = lat_pass[NITER];
   assign {f_valid, f_lon_zero} = lon_pass[NITER];

   always_comb begin
      lat_round  = lat_vec[NITER].z + ZW'(32'h8000);
      lat_coarse = lat_round[ZW-1:16];
      if (f_lat_zero) begin
         lat_in = '0;
      end else if (lat_coarse > (ZW-16)'(c2gs_pkg::LAT_MAX)) begin
         lat_in = AW'(c2gs_pkg::LAT_MAX);
      end else if (lat_coarse < -(ZW-16)'(c2gs_pkg::LAT_MAX)) begin
         lat_in = AW'(-c2gs_pkg::LAT_MAX);
      end else begin
         lat_in = lat_coarse[AW-1:0];
      end
      lon_round = {1'b0, lon_vec[NITER].z[31:0]} + 33'h8000;
      lon_in    = f_lon_zero ? '0 : lon_round[31:16];
   end

   // Output register; the chain moves whenever it is free
   logic          rsp_valid_ff;
   logic [71:0]   rsp_data_ff;
   assign advance = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= f_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= {7'd0, lon_in, lat_in, f_dist};
      end
   end

   assign req_tready = advance;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Latitude never leaves a quarter turn
   a_lat_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ($signed(rsp_tdata[48:33]) <= 16'sd16384)
                  && ($signed(rsp_tdata[48:33]) >= -16'sd16384))
      else $error("latitude out of range");

   // A point on the observer has both angles zero
   a_zero_point: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tdata[32:0] == '0)) |-> (rsp_tdata[64:33] == '0))
      else $error("zero distance with nonzero angle");

   // Nothing leaves straight after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // Padding bits stay clear
   a_pad_clear: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[71:65] == '0))
      else $error("padding set");
endmodule
`default_nettype wire
